// File: design/vertex_record_unpacker_assert.svh
// ----------------------------------------------------------------------------
// vertex_record_unpacker_assert.svh
// Assertion macros shared by the vertex record unpacker modules
// ----------------------------------------------------------------------------
`ifndef VERTEX_RECORD_UNPACKER_ASSERT_SVH
`define VERTEX_RECORD_UNPACKER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property must hold on every rising clock edge outside reset
`define VRU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define VRU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VRU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define VRU_ASSERT(lbl, clk, rst_n, prop, msg)
`define VRU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define VRU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: design/vru_pkg.sv
// ----------------------------------------------------------------------------
// vru_pkg
// Types, constants and helpers of the vertex record unpacker
// ----------------------------------------------------------------------------
package vru_pkg;

  localparam int MAX_UV_LAYERS    = 5;
  localparam int NORMAL_FRAC_BITS = 14;

  localparam int REC_DEPTH    = 32 + 4 * MAX_UV_LAYERS;
  localparam int POS_W        = $clog2(REC_DEPTH);
  localparam int STRIDE_W     = POS_W + 1;
  localparam int WORD_W       = POS_W - 2;
  localparam int LAYER_W      = 4;
  localparam int BASE_STRIDE  = 28;
  localparam int FIXED_BYTES  = 28;
  localparam int REGION_BASE  = 24;
  localparam int REGION_WORDS = MAX_UV_LAYERS + 2;
  localparam int RAM_AW       = $clog2(REGION_WORDS);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [31:0] UV_MULTIPLY_RESET = 32'sd8192;

  // 2^F = K*255 + R splits the unorm scaling into an exact and a small part
  localparam logic [31:0] UNORM_K = 32'((1 << NORMAL_FRAC_BITS) / 255);
  localparam logic [31:0] UNORM_R = 32'((1 << NORMAL_FRAC_BITS) % 255);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HAS_COLOR   = 3'd0,
    CFG_UV_LAYERS   = 3'd1,
    CFG_SELECTED_UV = 3'd2,
    CFG_UV_MODE     = 3'd3,
    CFG_UV_MULTIPLY = 3'd4,
    CFG_UV_OFFSET   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic               has_color;
    logic [2:0]         uv_layer_count;
    logic [2:0]         selected_uv;
    logic               uv_mode;
    logic signed [31:0] uv_multiply;
    logic signed [31:0] uv_offset;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_start;
  } in_t;

  typedef struct packed {
    logic [31:0]        position_x;
    logic [31:0]        position_y;
    logic [31:0]        position_z;
    logic [47:0]        normal_packed;
    logic [47:0]        tangent_packed;
    logic               handedness;
    logic signed [31:0] uv_u;
    logic signed [31:0] uv_v;
    logic               uv_valid;
    logic [31:0]        color_bgra;
    logic [31:0]        bone_indices;
    logic [31:0]        bone_weights;
  } out_t;

  // one complete record as handed from capture to decode
  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] weights;
    logic [31:0] indices;
    logic [23:0] normal_bytes;
    logic        hand_bit;
    logic [31:0] color;
    logic [23:0] tangent_bytes;
    logic [31:0] uv_word;
  } rec_t;

  function automatic logic [LAYER_W-1:0] clamp_layers(input logic [2:0] cnt);
    return (LAYER_W'(cnt) > LAYER_W'(MAX_UV_LAYERS)) ? LAYER_W'(MAX_UV_LAYERS)
                                                    : LAYER_W'(cnt);
  endfunction

endpackage

// File: design/vru_ram.sv
// ----------------------------------------------------------------------------
// vru_ram
// Generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module vru_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/vru_capture.sv
// ----------------------------------------------------------------------------
// vru_capture
// Byte position tracking, record byte storage and record snapshot
// ----------------------------------------------------------------------------
`include "vertex_record_unpacker_assert.svh"

module vru_capture (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  vru_pkg::in_t  in_data,
  input  vru_pkg::cfg_t cfg,
  output logic          rec_valid,
  input  logic          rec_ready,
  output vru_pkg::rec_t rec
);

  localparam int PW = vru_pkg::POS_W;
  localparam int SW = vru_pkg::STRIDE_W;
  localparam int WW = vru_pkg::WORD_W;
  localparam int AW = vru_pkg::RAM_AW;

  logic [vru_pkg::LAYER_W-1:0] layers;
  logic [SW-1:0]               stride;
  logic [PW-1:0]               pos_in;
  logic                        done_in;
  logic                        in_accept;

  logic [PW-1:0] bp_r, bp_nxt;
  logic          s1_v_r, s1_v_nxt;
  logic [7:0]    s1_byte_r;
  logic [PW-1:0] s1_pos_r;
  logic          s1_done_r;
  logic          s1_go;

  logic [7:0]  fix_r [vru_pkg::FIXED_BYTES];
  logic [7:0]  asm_r [3];
  logic [23:0] asm_word;
  logic [WW-1:0] pos_word;
  logic [WW-1:0] tan_word;
  logic          tan_from_asm;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] uv_raddr;
  logic [AW-1:0] tan_raddr;
  logic [31:0]   uv_rdata;
  logic [31:0]   tan_rdata;

  logic          s2_v_r, s2_v_nxt;
  logic          s2_load;
  logic          s2_free;
  vru_pkg::rec_t s2_rec_r;
  logic          s2_tan_asm_r;
  logic [23:0]   s2_tan_bytes_r;

  // position and record end are settled when the byte is taken
  assign layers  = vru_pkg::clamp_layers(cfg.uv_layer_count);
  assign stride  = SW'(vru_pkg::BASE_STRIDE) + (SW'(cfg.has_color) << 2) + (SW'(layers) << 2);
  assign pos_in  = in_data.buffer_start ? '0 : bp_r;
  assign done_in = (SW'(pos_in) + SW'(1)) >= stride;

  assign s2_free   = !s2_v_r || rec_ready;
  assign s1_go     = s1_v_r && (!s1_done_r || s2_free);
  assign in_stall  = s1_v_r && !s1_go;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    bp_nxt = bp_r;
    if (in_accept) begin
      bp_nxt = done_in ? '0 : pos_in + PW'(1);
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_accept) begin
      s1_v_nxt = 1'b1;
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_r   <= '0;
      s1_v_r <= 1'b0;
    end else begin
      bp_r   <= bp_nxt;
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_data.data_byte;
      s1_pos_r  <= pos_in;
      s1_done_r <= done_in;
    end
  end

  // fixed part of the record lives in its own byte registers
  always_ff @(posedge clk) begin
    if (s1_go && (SW'(s1_pos_r) < SW'(vru_pkg::FIXED_BYTES))) begin
      fix_r[s1_pos_r[4:0]] <= s1_byte_r;
    end
  end

  // lower three bytes of the word being gathered
  always_ff @(posedge clk) begin
    if (s1_go && (s1_pos_r[1:0] != 2'd3)) begin
      asm_r[s1_pos_r[1:0]] <= s1_byte_r;
    end
  end

  assign asm_word = {asm_r[2], asm_r[1], asm_r[0]};

  // word index within the colour/uv/tangent region
  assign pos_word     = s1_pos_r[PW-1:2] - WW'(vru_pkg::REGION_BASE / 4);
  assign tan_word     = WW'(cfg.has_color) + WW'(layers);
  assign tan_from_asm = (pos_word == tan_word);

  assign ram_we    = s1_go && (SW'(s1_pos_r) >= SW'(vru_pkg::REGION_BASE))
                     && (s1_pos_r[1:0] == 2'd3);
  assign ram_waddr = AW'(pos_word);
  assign ram_wdata = {s1_byte_r, asm_word};
  assign ram_re    = s1_go && s1_done_r;
  assign uv_raddr  = AW'(WW'(cfg.has_color) + WW'(cfg.selected_uv));
  assign tan_raddr = AW'(tan_word);

  vru_ram #(
    .WIDTH (32),
    .DEPTH (vru_pkg::REGION_WORDS)
  ) u_uv_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (uv_raddr),
    .rd_data (uv_rdata)
  );

  vru_ram #(
    .WIDTH (32),
    .DEPTH (vru_pkg::REGION_WORDS)
  ) u_tan_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (tan_raddr),
    .rd_data (tan_rdata)
  );

  assign s2_load = s1_go && s1_done_r;

  always_comb begin
    s2_v_nxt = s2_v_r;
    if (s2_load) begin
      s2_v_nxt = 1'b1;
    end else if (rec_ready) begin
      s2_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s2_v_nxt;
    end
  end

  // snapshot so a following record may refill the byte registers
  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_rec_r.pos_x        <= {fix_r[3], fix_r[2], fix_r[1], fix_r[0]};
      s2_rec_r.pos_y        <= {fix_r[7], fix_r[6], fix_r[5], fix_r[4]};
      s2_rec_r.pos_z        <= {fix_r[11], fix_r[10], fix_r[9], fix_r[8]};
      s2_rec_r.weights      <= {fix_r[15], fix_r[14], fix_r[13], fix_r[12]};
      s2_rec_r.indices      <= {fix_r[19], fix_r[18], fix_r[17], fix_r[16]};
      s2_rec_r.normal_bytes <= {fix_r[22], fix_r[21], fix_r[20]};
      s2_rec_r.hand_bit     <= fix_r[23][7];
      s2_rec_r.color        <= {fix_r[27], fix_r[26], fix_r[25], fix_r[24]};
      s2_rec_r.tangent_bytes <= '0;
      s2_rec_r.uv_word      <= '0;
      s2_tan_asm_r          <= tan_from_asm;
      s2_tan_bytes_r        <= asm_word;
    end
  end

  always_comb begin
    rec               = s2_rec_r;
    rec.tangent_bytes = s2_tan_asm_r ? s2_tan_bytes_r : tan_rdata[23:0];
    rec.uv_word       = uv_rdata;
  end

  assign rec_valid = s2_v_r;

  `VRU_ASSERT(a_bp_range, clk, rst_n, (SW'(bp_r) < SW'(vru_pkg::REC_DEPTH)), "byte position beyond record depth")
  `VRU_ASSERT_IMP(a_done_pos, clk, rst_n, s1_v_r && s1_done_r, (SW'(s1_pos_r) >= SW'(vru_pkg::BASE_STRIDE - 1)), "record closed before minimum stride")
  `VRU_ASSERT_NXT(a_s2_hold, clk, rst_n, s2_v_r && !rec_ready, s2_v_r, "pending record lost while held")

endmodule

// File: design/vru_decode.sv
// ----------------------------------------------------------------------------
// vru_decode
// Field decode of a complete record into the result register
// ----------------------------------------------------------------------------
`include "vertex_record_unpacker_assert.svh"

module vru_decode (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rec_valid,
  output logic          rec_ready,
  input  vru_pkg::rec_t rec,
  input  vru_pkg::cfg_t cfg,
  output logic          out_valid,
  input  logic          out_stall,
  output vru_pkg::out_t out_data
);

  // round((2v-255) * 2^F / 255) using the exact K part plus a small reciprocal
  function automatic logic [15:0] unorm_dec(input logic [7:0] v);
    logic [7:0]  mag;
    logic [31:0] hi;
    logic [31:0] y;
    logic [31:0] lo;
    logic [31:0] q;
    mag = {v[7] ? v[6:0] : ~v[6:0], 1'b1};
    hi  = 32'(mag) * vru_pkg::UNORM_K;
    y   = 32'(mag) * vru_pkg::UNORM_R + 32'd127;
    lo  = ((y + 32'd1) * 32'd257) >> 16;
    q   = hi + lo;
    return v[7] ? q[15:0] : 16'(32'd0 - q);
  endfunction

  function automatic logic [47:0] unorm_triple(input logic [23:0] b);
    return {unorm_dec(b[23:16]), unorm_dec(b[15:8]), unorm_dec(b[7:0])};
  endfunction

  function automatic logic signed [31:0] uv_dec(
    input logic [15:0]        raw,
    input logic               mode,
    input logic signed [31:0] mult,
    input logic signed [31:0] offs
  );
    logic signed [15:0] s;
    logic signed [47:0] p;
    logic signed [47:0] pr;
    logic signed [40:0] r;
    s  = raw;
    p  = s * mult;
    pr = p + 48'sd128;
    // arithmetic shift by eight floors toward minus infinity
    r  = {pr[47], pr[47:8]} + {{9{offs[31]}}, offs};
    if (!mode) begin
      return {{11{raw[15]}}, raw, 5'b0};
    end else if (r[40:31] == {10{r[40]}}) begin
      return r[31:0];
    end else begin
      return r[40] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end
  endfunction

  logic [vru_pkg::LAYER_W-1:0] layers;
  logic                        uv_ok;
  logic                        load;
  logic                        out_valid_r, out_valid_nxt;
  vru_pkg::out_t               out_data_r;
  vru_pkg::out_t               out_data_nxt;

  assign layers    = vru_pkg::clamp_layers(cfg.uv_layer_count);
  assign uv_ok     = vru_pkg::LAYER_W'(cfg.selected_uv) < layers;
  assign rec_ready = !out_valid_r || !out_stall;
  assign load      = rec_valid && rec_ready;

  always_comb begin
    out_data_nxt.position_x     = rec.pos_x;
    out_data_nxt.position_y     = rec.pos_y;
    out_data_nxt.position_z     = rec.pos_z;
    out_data_nxt.normal_packed  = unorm_triple(rec.normal_bytes);
    out_data_nxt.tangent_packed = unorm_triple(rec.tangent_bytes);
    out_data_nxt.handedness     = rec.hand_bit;
    out_data_nxt.uv_valid       = uv_ok;
    if (uv_ok) begin
      out_data_nxt.uv_u = uv_dec(rec.uv_word[15:0], cfg.uv_mode, cfg.uv_multiply,
                                 cfg.uv_offset);
      out_data_nxt.uv_v = uv_dec(rec.uv_word[31:16], cfg.uv_mode, cfg.uv_multiply,
                                 cfg.uv_offset);
    end else begin
      out_data_nxt.uv_u = '0;
      out_data_nxt.uv_v = '0;
    end
    out_data_nxt.color_bgra   = cfg.has_color ? rec.color : 32'd0;
    out_data_nxt.bone_indices = rec.indices;
    out_data_nxt.bone_weights = rec.weights;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `VRU_ASSERT_IMP(a_uv_zero, clk, rst_n, out_valid_r && !out_data_r.uv_valid, (out_data_r.uv_u == 32'sd0) && (out_data_r.uv_v == 32'sd0), "uv fields not cleared for missing layer")
  `VRU_ASSERT_NXT(a_load_shows, clk, rst_n, load, out_valid_r, "loaded vertex not presented")
  `VRU_ASSERT_IMP(a_ready_free, clk, rst_n, !out_valid_r, rec_ready, "empty result register refuses a record")

endmodule

// File: design/vertex_record_unpacker.sv
// ----------------------------------------------------------------------------
// vertex_record_unpacker
// Byte-stream vertex buffer to decoded vertex converter
// ----------------------------------------------------------------------------
// Takes one buffer byte per clock and emits one decoded vertex for each
// complete record (stride 28 bytes, plus 4 with colour, plus 4 per uv layer).
// Input rate is one byte per cycle, set by the byte-wide input channel; the
// block only stalls input when the result register holds a vertex that is not
// taken and the record stage behind it is also full. A vertex passes the byte
// stage, record snapshot and result register. A buffer_start request begins a
// new record and drops any partial one. Registers are written by the user via
// the cfg port while no record is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module vertex_record_unpacker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  vru_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output vru_pkg::out_t                    out_data,
  input  logic                             cfg_we,
  input  logic [vru_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vru_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  vru_pkg::cfg_t cfg_r, cfg_nxt;
  vru_pkg::rec_t rec;
  logic          rec_valid;
  logic          rec_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (vru_pkg::cfg_idx_t'(cfg_index))
        vru_pkg::CFG_HAS_COLOR:   cfg_nxt.has_color      = cfg_wdata[0];
        vru_pkg::CFG_UV_LAYERS:   cfg_nxt.uv_layer_count = cfg_wdata[2:0];
        vru_pkg::CFG_SELECTED_UV: cfg_nxt.selected_uv    = cfg_wdata[2:0];
        vru_pkg::CFG_UV_MODE:     cfg_nxt.uv_mode        = cfg_wdata[0];
        vru_pkg::CFG_UV_MULTIPLY: cfg_nxt.uv_multiply    = cfg_wdata[31:0];
        vru_pkg::CFG_UV_OFFSET:   cfg_nxt.uv_offset      = cfg_wdata[31:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.has_color      <= 1'b0;
      cfg_r.uv_layer_count <= '0;
      cfg_r.selected_uv    <= '0;
      cfg_r.uv_mode        <= 1'b0;
      cfg_r.uv_multiply    <= vru_pkg::UV_MULTIPLY_RESET;
      cfg_r.uv_offset      <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  vru_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec)
  );

  vru_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
